FILE: src/ngh_pkg.sv
// Shared types and constants for the noise gate with hold.
// Holds register defaults, register indexes, the sequencer state type and the
// control and status bundles. No dependencies.
package ngh_pkg;

   // Default field widths.
   localparam int SAMPLE_BITS_DEF = 24;
   localparam int COEFF_BITS_DEF  = 16;

   // The hold counter width is fixed.
   localparam int HOLD_BITS = 16;

   // Register index port width.
   localparam int CSR_ADDR_BITS = 3;

   // Register values after reset.
   localparam int unsigned THRESHOLD_RESET = 83886;
   localparam int unsigned ATTACK_RESET    = 64068;
   localparam int unsigned RELEASE_RESET   = 65520;
   localparam int unsigned HOLD_RESET      = 2205;
   localparam int unsigned RANGE_RESET     = 7;

   // Register indexes.
   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_THRESHOLD = 3'd0,
      CSR_ATTACK    = 3'd1,
      CSR_RELEASE   = 3'd2,
      CSR_HOLD      = 3'd3,
      CSR_RANGE     = 3'd4
   } csr_index_type;

   // Which product the shared serial multiplier forms.
   typedef enum logic [1:0] {
      OP_ENV,
      OP_GAIN,
      OP_OUT
   } mul_op_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ENV_START,
      ST_ENV_RUN,
      ST_ENV_WR,
      ST_DECIDE,
      ST_GAIN_START,
      ST_GAIN_RUN,
      ST_GAIN_WR,
      ST_OUT_START,
      ST_OUT_RUN,
      ST_FINISH
   } state_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic req_valid;
      logic mul_done;
      logic gate_hi;
      logic hold_nz;
      logic rsp_free;
   } status_type;

   // Controls from the sequencer to the datapath.
   typedef struct packed {
      logic       idle;
      logic       mul_start;
      mul_op_type op;
      logic       env_write;
      logic       gate_decide;
      logic       gain_write;
      logic       rsp_load;
   } ctrl_type;

endpackage

FILE: src/noise_gate_hold_envelope.sv
// Top level of the noise gate with hold: registers, datapath and output stage.
// Depends on ngh_pkg, ngh_serial_mul and ngh_ctrl.
//
// Usage:
// Items enter on req_ (sample, block_start) and leave on rsp_ (out_sample,
// gate_open), each channel with valid and stall; an item moves at a clock
// edge with valid high and stall low. Settings are written on csr_ (index,
// data, valid, ready); ready is always high, writes belong to idle periods.
// One item is worked on at a time. Each item takes three or two products on
// one bit-serial multiplier that retires one multiplier bit per cycle, so
// the rate is set by that multiplier: an item takes two products while the
// gate is open or holding, and three while it is closed. The result is
// loaded into the output register after the output product and stays there
// until taken; the next item is accepted while the result waits. If the
// receiver stalls, the block finishes the next item and then holds it until
// the output frees. Reset loads the register defaults, clears envelope,
// gain, hold and the gate flag, and empties the output register.
module noise_gate_hold_envelope
   import ngh_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int COEFF_BITS  = COEFF_BITS_DEF,
   localparam int VAL_BITS   = (SAMPLE_BITS > COEFF_BITS + 1) ? SAMPLE_BITS : COEFF_BITS + 1,
   localparam int CSR_BITS   = (VAL_BITS > HOLD_BITS) ? VAL_BITS : HOLD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_block_start,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_sample,
   output logic                          rsp_gate_open,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_ADDR_BITS-1:0]      csr_addr,
   input  logic [CSR_BITS-1:0]           csr_wdata
);

   localparam int GAIN_BITS = COEFF_BITS + 1;
   localparam int A_BITS    = VAL_BITS + 1;
   localparam int B_BITS    = COEFF_BITS + 1;
   localparam int P_BITS    = A_BITS + B_BITS;
   localparam int ACC_BITS  = P_BITS + 1;
   localparam logic [ACC_BITS-1:0]    ROUND_HALF = ACC_BITS'(1) << (COEFF_BITS - 1);
   localparam logic [GAIN_BITS-1:0]   GAIN_ONE   = GAIN_BITS'(1) << COEFF_BITS;
   localparam logic [SAMPLE_BITS:0]   HALF_RANGE = (SAMPLE_BITS + 1)'(1) << (SAMPLE_BITS - 1);

   // Configuration registers.
   logic [SAMPLE_BITS-1:0] threshold_ff;
   logic [COEFF_BITS-1:0]  attack_ff;
   logic [COEFF_BITS-1:0]  release_ff;
   logic [HOLD_BITS-1:0]   hold_samples_ff;
   logic [GAIN_BITS-1:0]   range_ff;

   // Gate state and item registers.
   logic [SAMPLE_BITS-1:0] env_ff;
   logic [GAIN_BITS-1:0]   gain_ff;
   logic [HOLD_BITS-1:0]   hold_ff;
   logic                   open_ff;
   logic [SAMPLE_BITS-1:0] mag_ff, mag_in;
   logic                   neg_ff;

   // Output register.
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic                          rsp_open_ff;

   // Multiplier interface.
   logic signed [A_BITS-1:0] mul_a;
   logic        [B_BITS-1:0] mul_b;
   logic                     mul_busy, mul_done;
   logic signed [P_BITS-1:0] mul_p;

   logic [ACC_BITS-1:0]    env_acc, gain_acc;
   logic [SAMPLE_BITS:0]   prod, prod_sat;
   logic [SAMPLE_BITS-1:0] out_value;
   logic                   item_take, rsp_take, rsp_free;

   status_type status;
   ctrl_type   ctrl;

   assign csr_ready = 1'b1;
   assign item_take = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !ctrl.idle;

   // Register writes; bits beyond a register's width are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= SAMPLE_BITS'(THRESHOLD_RESET);
         attack_ff       <= COEFF_BITS'(ATTACK_RESET);
         release_ff      <= COEFF_BITS'(RELEASE_RESET);
         hold_samples_ff <= HOLD_BITS'(HOLD_RESET);
         range_ff        <= GAIN_BITS'(RANGE_RESET);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_addr))
            CSR_THRESHOLD: threshold_ff    <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_ATTACK:    attack_ff       <= csr_wdata[COEFF_BITS-1:0];
            CSR_RELEASE:   release_ff      <= csr_wdata[COEFF_BITS-1:0];
            CSR_HOLD:      hold_samples_ff <= csr_wdata[HOLD_BITS-1:0];
            CSR_RANGE:     range_ff        <= csr_wdata[GAIN_BITS-1:0];
            default:       threshold_ff    <= threshold_ff;
         endcase
      end
   end

   // Sample magnitude; the most negative sample maps to half range.
   assign mag_in = req_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-req_sample) : req_sample;

   // Operand selection for the shared multiplier. Each smoothing step is
   // target*ONE + c*(old - target), so only the difference is multiplied.
   always_comb begin
      unique case (ctrl.op)
         OP_ENV: begin
            mul_a = $signed(A_BITS'(env_ff) - A_BITS'(mag_ff));
            mul_b = (mag_ff > env_ff) ? B_BITS'(attack_ff) : B_BITS'(release_ff);
         end
         OP_GAIN: begin
            mul_a = $signed(A_BITS'(gain_ff) - A_BITS'(range_ff));
            mul_b = B_BITS'(release_ff);
         end
         OP_OUT: begin
            mul_a = $signed(A_BITS'(mag_ff));
            mul_b = gain_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   ngh_serial_mul #(
      .A_BITS (A_BITS),
      .B_BITS (B_BITS)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (ctrl.mul_start),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .busy    (mul_busy),
      .done    (mul_done),
      .product (mul_p)
   );

   // Rounded smoothing results from the finished product.
   assign env_acc  = (ACC_BITS'(mag_ff) << COEFF_BITS) + ACC_BITS'(mul_p) + ROUND_HALF;
   assign gain_acc = (ACC_BITS'(range_ff) << COEFF_BITS) + ACC_BITS'(mul_p) + ROUND_HALF;

   // Output magnitude, saturated and given back its sign.
   always_comb begin
      prod = mul_p[COEFF_BITS +: SAMPLE_BITS + 1];
      if (neg_ff) begin
         prod_sat  = (prod > HALF_RANGE) ? HALF_RANGE : prod;
         out_value = SAMPLE_BITS'((SAMPLE_BITS + 1)'(0) - prod_sat);
      end else begin
         prod_sat  = (prod > HALF_RANGE - 1'b1) ? (HALF_RANGE - 1'b1) : prod;
         out_value = prod_sat[SAMPLE_BITS-1:0];
      end
   end

   // Status toward the sequencer.
   always_comb begin
      status.req_valid = req_valid;
      status.mul_done  = mul_done;
      status.gate_hi   = (env_ff >= threshold_ff);
      status.hold_nz   = (hold_ff != '0);
      status.rsp_free  = rsp_free;
   end

   ngh_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // Gate state: cleared by block start, then envelope, gate decision and
   // gain glide in the order the sequencer steps through them.
   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff  <= '0;
         gain_ff <= '0;
         hold_ff <= '0;
         open_ff <= 1'b0;
      end else begin
         priority if (item_take && req_block_start) begin
            env_ff  <= '0;
            gain_ff <= '0;
            hold_ff <= '0;
            open_ff <= 1'b0;
         end else if (ctrl.env_write) begin
            env_ff <= env_acc[COEFF_BITS +: SAMPLE_BITS];
         end else if (ctrl.gate_decide) begin
            priority if (status.gate_hi) begin
               open_ff <= 1'b1;
               hold_ff <= hold_samples_ff;
               gain_ff <= GAIN_ONE;
            end else if (status.hold_nz) begin
               hold_ff <= hold_ff - HOLD_BITS'(1);
               gain_ff <= GAIN_ONE;
            end else begin
               open_ff <= 1'b0;
            end
         end else if (ctrl.gain_write) begin
            gain_ff <= gain_acc[COEFF_BITS +: GAIN_BITS];
         end
      end
   end

   // Item registers.
   always_ff @(posedge clock) begin
      if (item_take) begin
         mag_ff <= mag_in;
         neg_ff <= req_sample[SAMPLE_BITS-1];
      end
   end

   // Output register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (ctrl.rsp_load) begin
         rsp_sample_ff <= $signed(out_value);
         rsp_open_ff   <= open_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = rsp_sample_ff;
   assign rsp_gate_open  = rsp_open_ff;

   // A running hold count always belongs to an open gate.
   assert property (@(posedge clock) disable iff (reset)
      (hold_ff != '0) |-> open_ff)
      else $error("hold count running while gate is closed");

   // An accepted item starts the envelope product in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      item_take |=> ctrl.mul_start)
      else $error("envelope product did not start after item acceptance");

   // The multiplier is never restarted while it is still working.
   assert property (@(posedge clock) disable iff (reset)
      ctrl.mul_start |-> !mul_busy)
      else $error("multiplier started while busy");

   // A result is loaded only into a free or emptying output register.
   assert property (@(posedge clock) disable iff (reset)
      ctrl.rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwrote an untaken result");

endmodule

FILE: src/ngh_serial_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle, MSB first.
// Signed multiplicand times unsigned multiplier. Depends on nothing.
module ngh_serial_mul #(
   parameter int A_BITS = 25,
   parameter int B_BITS = 17
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [A_BITS-1:0]         mul_a,
   input  logic        [B_BITS-1:0]         mul_b,
   output logic                             busy,
   output logic                             done,
   output logic signed [A_BITS+B_BITS-1:0]  product
);

   localparam int P_BITS = A_BITS + B_BITS;
   localparam int C_BITS = $clog2(B_BITS + 1);

   logic signed [A_BITS-1:0] a_ff;
   logic        [B_BITS-1:0] b_ff, b_in;
   logic signed [P_BITS-1:0] p_ff, p_in, addend;
   logic        [C_BITS-1:0] cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;

   // The last step is the one with a single bit left.
   assign done    = busy_ff && (cnt_ff == C_BITS'(1));
   assign busy    = busy_ff;
   assign product = p_ff;

   // One Horner step: double the partial product and add the multiplicand
   // when the current multiplier bit is set.
   always_comb begin
      addend  = b_ff[B_BITS-1] ? P_BITS'(a_ff) : '0;
      p_in    = p_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         p_in    = '0;
         b_in    = mul_b;
         cnt_in  = C_BITS'(B_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         p_in   = (p_ff <<< 1) + addend;
         b_in   = b_ff << 1;
         cnt_in = cnt_ff - C_BITS'(1);
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Operand and partial product registers.
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= mul_a;
      end
      b_ff <= b_in;
      p_ff <= p_in;
   end

endmodule

FILE: src/ngh_ctrl.sv
// Sequencer for the noise gate: steps one item through envelope, decision,
// gain (only with the gate closed) and output products. Depends on ngh_pkg.
module ngh_ctrl
   import ngh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output ctrl_type   ctrl
);

   state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (status.req_valid) begin
               state_in = ST_ENV_START;
            end
         end
         ST_ENV_START: state_in = ST_ENV_RUN;
         ST_ENV_RUN: begin
            if (status.mul_done) begin
               state_in = ST_ENV_WR;
            end
         end
         ST_ENV_WR: state_in = ST_DECIDE;
         ST_DECIDE: begin
            priority if (status.gate_hi || status.hold_nz) begin
               state_in = ST_OUT_START;
            end else begin
               state_in = ST_GAIN_START;
            end
         end
         ST_GAIN_START: state_in = ST_GAIN_RUN;
         ST_GAIN_RUN: begin
            if (status.mul_done) begin
               state_in = ST_GAIN_WR;
            end
         end
         ST_GAIN_WR: state_in = ST_OUT_START;
         ST_OUT_START: state_in = ST_OUT_RUN;
         ST_OUT_RUN: begin
            if (status.mul_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs decoded from the state.
   always_comb begin
      ctrl = '0;
      ctrl.op = OP_ENV;
      unique case (state_ff)
         ST_IDLE:       ctrl.idle = 1'b1;
         ST_ENV_START: begin
            ctrl.mul_start = 1'b1;
            ctrl.op        = OP_ENV;
         end
         ST_ENV_WR:     ctrl.env_write = 1'b1;
         ST_DECIDE:     ctrl.gate_decide = 1'b1;
         ST_GAIN_START: begin
            ctrl.mul_start = 1'b1;
            ctrl.op        = OP_GAIN;
         end
         ST_GAIN_WR:    ctrl.gain_write = 1'b1;
         ST_OUT_START: begin
            ctrl.mul_start = 1'b1;
            ctrl.op        = OP_OUT;
         end
         ST_FINISH:     ctrl.rsp_load = status.rsp_free;
         default:       ctrl.idle = 1'b0;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
